### hw/rtl/fs_pkg.sv
package fs_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int TIME_W        = 64;
    localparam int COUNT_W       = 32;
    localparam int HALF_LIFE_W   = 50;
    localparam int FSAT_W        = 16;
    localparam int WEIGHT_W      = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 50;
    localparam int IN_W          = 3 * TIME_W + COUNT_W;
    localparam int POW_BITS      = 24;
    localparam int EXP_FRAC_BITS = 16;
    localparam int EXP_INT_BITS  = 5;
    localparam int EXP_LIMIT     = 17;
    localparam int WEIGHT_ONE    = 65536;

    localparam logic [HALF_LIFE_W-1:0] HALF_LIFE_RST = 50'd3600000000000;
    localparam logic [FSAT_W-1:0]      FSAT_RST      = 16'd16;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_RST    = 17'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_LIFE = 2'd0,
        REG_FREQ_SAT  = 2'd1,
        REG_WEIGHT    = 2'd2
    } cfg_reg_t;

    // 2^(-2^-(i+1)) in Q0.24
    function automatic logic [POW_BITS-1:0] pow_tab(input logic [3:0] i);
        logic [POW_BITS-1:0] t;
        case (i)
            4'd0:    t = 24'd11863283;
            4'd1:    t = 24'd14107901;
            4'd2:    t = 24'd15384775;
            4'd3:    t = 24'd16065917;
            4'd4:    t = 24'd16417715;
            4'd5:    t = 24'd16596492;
            4'd6:    t = 24'd16686609;
            4'd7:    t = 24'd16731851;
            4'd8:    t = 24'd16754518;
            4'd9:    t = 24'd16765863;
            4'd10:   t = 24'd16771539;
            4'd11:   t = 24'd16774377;
            4'd12:   t = 24'd16775796;
            4'd13:   t = 24'd16776506;
            4'd14:   t = 24'd16776861;
            default: t = 24'd16777039;
        endcase
        return t;
    endfunction

endpackage

### hw/rtl/fs_mix.sv
module fs_mix #(
    parameter int FRAC_BITS = fs_pkg::DEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [FRAC_BITS:0]            rec,
    input  logic [FRAC_BITS:0]            freq,
    input  logic [fs_pkg::WEIGHT_W-1:0]   weight,
    output logic                          out_valid,
    output logic [FRAC_BITS:0]            score
);
    import fs_pkg::*;

    localparam int PW = WEIGHT_W + FRAC_BITS + 1;
    localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(WEIGHT_ONE);
    localparam logic [FRAC_BITS+2:0] S_ONE = (FRAC_BITS+3)'(1) << FRAC_BITS;

    logic [WEIGHT_W-1:0] w_sat;
    logic [PW-1:0]       wr_reg, wf_reg, wr_next, wf_next;
    logic [PW:0]         sum;
    logic [FRAC_BITS+2:0] sh;
    logic [FRAC_BITS:0]  score_reg, score_next;
    logic                v1_reg, v2_reg;

    always_comb
    begin
        w_sat   = (weight > W_ONE) ? W_ONE : weight;
        wr_next = PW'(w_sat) * PW'(rec);
        wf_next = PW'(W_ONE - w_sat) * PW'(freq);
        sum     = (PW+1)'(wr_reg) + (PW+1)'(wf_reg) + (PW+1)'(WEIGHT_ONE / 2);
        sh      = sum[PW:16];
        score_next = (sh > S_ONE) ? S_ONE[FRAC_BITS:0] : sh[FRAC_BITS:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wr_reg    <= wr_next;
            wf_reg    <= wf_next;
            score_reg <= score_next;
        end
    end

    assign out_valid = v2_reg;
    assign score     = score_reg;

endmodule

### hw/rtl/frecency_score.sv
// frecency scorer: takes one item per cycle unless the output stalls (now, last read,
// last write, access count) and returns one score in unsigned Q1.F, 0..1.0, as
// w*2^(-age/half_life) + (1-w)*n/(n+sat). the pipe has one input stage, one restoring
// divider step per stage that yields 5 integer and 16 fraction exponent bits while the
// frequency quotient is formed alongside, sixteen stages of 25x24 multiply-and-round
// for the fractional power, one stage of rounding shift, and two stages of weighting.
// a stall on the output freezes the whole pipe, so nothing is lost or repeated.
// configuration writes are always taken (cfg_ready is high) and must only happen while
// no item is in flight; register 0 is the half-life in ns, 1 the frequency saturation
// count and 2 the recency weight in Q1.16
module frecency_score #(
    parameter int SCORE_FRAC_BITS = fs_pkg::DEF_FRAC_BITS,
    parameter int OUT_W = ((SCORE_FRAC_BITS + 8) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // now_ns[63:0], last_read_ns[127:64], last_write_ns[191:128], access_count[223:192]
    input  logic [fs_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // score[F:0], zero padded above
    output logic [OUT_W-1:0]                m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fs_pkg::*;

    localparam int F    = SCORE_FRAC_BITS;
    localparam int NEXP = EXP_INT_BITS + EXP_FRAC_BITS;       // exponent bits
    localparam int NDIV = (F + 1 > NEXP) ? F + 1 : NEXP;     // divider stages
    localparam int NP   = EXP_FRAC_BITS;                     // power stages
    localparam int PR   = NDIV + NP + 1;                     // recency stage
    localparam int FRW  = F + COUNT_W + 1;                   // freq remainder width
    localparam int DW   = COUNT_W + 1;

    // configuration registers
    logic [HALF_LIFE_W-1:0] hl_reg;
    logic [FSAT_W-1:0]      fsat_reg;
    logic [WEIGHT_W-1:0]    w_reg;
    logic [HALF_LIFE_W-1:0] h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hl_reg   <= HALF_LIFE_RST;
            fsat_reg <= FSAT_RST;
            w_reg    <= WEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HALF_LIFE: hl_reg   <= cfg_data[HALF_LIFE_W-1:0];
                REG_FREQ_SAT:  fsat_reg <= cfg_data[FSAT_W-1:0];
                REG_WEIGHT:    w_reg    <= cfg_data[WEIGHT_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    // zero half-life acts as one
    assign h_eff = (hl_reg == '0) ? HALF_LIFE_W'(1) : hl_reg;

    // pipe enable: everything moves unless a finished score is held
    logic en;
    logic mix_valid;
    logic [F:0] score;
    assign en            = !mix_valid || m_axis_tready;
    assign s_axis_tready = en;

    logic                 v_reg    [0:PR];
    logic [TIME_W-1:0]    arem_reg [0:NDIV];
    logic [FRW-1:0]       frem_reg [0:NDIV];
    logic [DW-1:0]        d_reg    [0:NDIV];
    logic [NEXP-1:0]      eb_reg   [1:PR-1];
    logic                 over_reg [1:PR-1];
    logic [F:0]           fq_reg   [0:PR];
    logic [POW_BITS:0]    p_reg    [NDIV+1:NDIV+NP];
    logic [F:0]           rec_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= PR; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= s_axis_tvalid;
            for (int i = 1; i <= PR; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // input stage: age from the later stamp, frequency numerator and divisor
    logic [TIME_W-1:0]  now_v, lr_v, lw_v, last_v, age_next;
    logic [COUNT_W-1:0] n_v;
    logic [DW-1:0]      d_sum, d_next;
    logic [FRW-1:0]     frem_next;

    always_comb
    begin
        now_v    = s_axis_tdata[TIME_W-1:0];
        lr_v     = s_axis_tdata[2*TIME_W-1:TIME_W];
        lw_v     = s_axis_tdata[3*TIME_W-1:2*TIME_W];
        n_v      = s_axis_tdata[IN_W-1:3*TIME_W];
        last_v   = (lr_v > lw_v) ? lr_v : lw_v;
        age_next = (now_v > last_v) ? now_v - last_v : '0;
        d_sum    = DW'(n_v) + DW'(fsat_reg);
        // zero divisor: all-ones divisor over a zero numerator gives zero
        if (d_sum == '0)
        begin
            d_next    = '1;
            frem_next = '0;
        end
        else
        begin
            d_next    = d_sum;
            frem_next = (FRW'(n_v) << F) + FRW'(d_sum >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arem_reg[0] <= age_next;
            frem_reg[0] <= frem_next;
            d_reg[0]    <= d_next;
            fq_reg[0]   <= '0;
        end
    end

    // divider: the first NEXP stages each yield one exponent bit, the first F+1 one frequency quotient bit
    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        localparam int KI = (j < EXP_INT_BITS) ? EXP_INT_BITS - 1 - j : 0;
        localparam int KF = (j <= F) ? F - j : 0;
        logic [TIME_W-1:0] a_in, a_cmp, a_next;
        logic [NEXP-1:0]   eb_in, eb_next;
        logic              over_next, abit;
        logic [FRW-1:0]    f_cmp, frem_nx;
        logic [F:0]        fq_next;

        always_comb
        begin
            a_in  = arem_reg[j];
            eb_in = (j == 0) ? '0 : eb_reg[(j == 0) ? 1 : j];
            a_cmp = '0;
            abit  = 1'b0;
            over_next = (j == 0) ? (a_in >= (TIME_W'(h_eff) << EXP_INT_BITS))
                                 : over_reg[(j == 0) ? 1 : j];
            if (j < EXP_INT_BITS)
            begin
                a_cmp = TIME_W'(h_eff) << KI;
                abit  = (a_in >= a_cmp);
                a_next = abit ? a_in - a_cmp : a_in;
            end
            else if (j < NEXP)
            begin
                a_cmp = a_in << 1;
                abit  = (a_cmp >= TIME_W'(h_eff));
                a_next = abit ? a_cmp - TIME_W'(h_eff) : a_cmp;
            end
            else
                a_next = a_in;
            eb_next = (j < NEXP) ? {eb_in[NEXP-2:0], abit} : eb_in;

            f_cmp   = FRW'(d_reg[j]) << KF;
            frem_nx = frem_reg[j];
            fq_next = fq_reg[j];
            if (j <= F)
            begin
                fq_next = {fq_reg[j][F-1:0], (frem_reg[j] >= f_cmp)};
                if (frem_reg[j] >= f_cmp)
                    frem_nx = frem_reg[j] - f_cmp;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                arem_reg[j+1] <= a_next;
                eb_reg[j+1]   <= eb_next;
                over_reg[j+1] <= over_next;
                frem_reg[j+1] <= frem_nx;
                d_reg[j+1]    <= d_reg[j];
                fq_reg[j+1]   <= fq_next;
            end
        end
    end

    // fractional power: one table factor per stage, rounded half up
    for (genvar k = 0; k < NP; k++)
    begin : g_pow
        localparam int S = NDIV + k;
        logic [POW_BITS:0]       p_in, p_next;
        logic [2*POW_BITS:0]     prod;

        always_comb
        begin
            p_in = (k == 0) ? (POW_BITS+1)'(1) << POW_BITS
                            : p_reg[(k == 0) ? NDIV + 1 : S];
            prod = (2*POW_BITS+1)'(p_in) * (2*POW_BITS+1)'(pow_tab(4'(k)))
                 + ((2*POW_BITS+1)'(1) << (POW_BITS - 1));
            p_next = eb_reg[S][EXP_FRAC_BITS-1-k] ? prod[2*POW_BITS:POW_BITS] : p_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[S+1]    <= p_next;
                eb_reg[S+1]   <= eb_reg[S];
                over_reg[S+1] <= over_reg[S];
                fq_reg[S+1]   <= fq_reg[S];
            end
        end
    end

    // recency: rounding shift by the integer exponent, zero at and past the limit
    logic [EXP_INT_BITS-1:0] q_v;
    logic [5:0]              s_v;
    logic [POW_BITS+1:0]     rnd_v, rnd_inc;
    logic [F:0]              rec_next;

    always_comb
    begin
        q_v     = eb_reg[PR-1][NEXP-1:EXP_FRAC_BITS];
        s_v     = 6'(q_v) + 6'(POW_BITS - F);
        rnd_v   = {p_reg[PR-1], 1'b0} >> s_v;
        rnd_inc = rnd_v + (POW_BITS+2)'(1);
        if (over_reg[PR-1] || (q_v >= EXP_INT_BITS'(EXP_LIMIT)))
            rec_next = '0;
        else
            rec_next = rnd_inc[F+1:1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec_reg    <= rec_next;
            fq_reg[PR] <= fq_reg[PR-1];
        end
    end

    fs_mix #(.FRAC_BITS(F)) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[PR]),
        .rec       (rec_reg),
        .freq      (fq_reg[PR]),
        .weight    (w_reg),
        .out_valid (mix_valid),
        .score     (score)
    );

    assign m_axis_tvalid = mix_valid;
    assign m_axis_tdata  = OUT_W'(score);

endmodule

### hw/rtl/fs_checker.sv
module fs_checker #(
    parameter int SCORE_FRAC_BITS = fs_pkg::DEF_FRAC_BITS,
    parameter int OUT_W = ((SCORE_FRAC_BITS + 8) / 8) * 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [OUT_W-1:0]              m_axis_tdata
);

    localparam logic [OUT_W-1:0] ONE = OUT_W'(1) << SCORE_FRAC_BITS;

    // score never exceeds 1.0 and padding stays zero
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= ONE))
        else $error("score out of range");

    // held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("held result changed");

    // input side only blocks while a result waits
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

endmodule

bind frecency_score fs_checker #(
    .SCORE_FRAC_BITS (SCORE_FRAC_BITS),
    .OUT_W           (OUT_W)
) u_fs_checker (.*);
